>>> rtl/core/pot_to_led_pwm_setting_defines.svh
`ifndef POT_TO_LED_PWM_SETTING_DEFINES_SVH
`define POT_TO_LED_PWM_SETTING_DEFINES_SVH

// check on clk, quiet while rst_n is low
`define PTLPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// check on clk, active through reset
`define PTLPS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/ptlps_pkg.sv
package ptlps_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int TICK_W     = 8;
  localparam int FS_W       = 10;
  localparam int CFG_DATA_W = 10;

  localparam int LANES       = 2;
  localparam int LANE_SHIFT  = 0;
  localparam int LANE_BRIGHT = 1;

  localparam int LIN_STAGES  = 3;
  localparam int DIV_STAGES  = 4;
  localparam int DIV_BITS    = TICK_W / DIV_STAGES;
  localparam int PWM_STAGES  = 6;

  localparam int LIN_SPAN_W = 9;
  localparam int LIN_NUM_W  = 15;
  localparam int LIN_K      = 24;
  localparam int LIN_M_W    = 17;
  localparam int LIN_PROD_W = LIN_NUM_W + LIN_M_W;

  localparam int X60_W      = 14;
  localparam int MAG_W      = 16;
  localparam int M255_W     = 17;
  localparam int DIV255_K   = 24;
  localparam int DIV_PROD_W = MAG_W + M255_W;

  typedef enum logic [0:0] {
    CFG_BASE_PERIOD    = 1'b0,
    CFG_ADC_FULL_SCALE = 1'b1
  } cfg_idx_t;

  typedef logic [SAMPLE_W-1:0]   sample_t;
  typedef logic [TICK_W-1:0]     level_t;
  typedef logic [FS_W-1:0]       fs_t;
  typedef logic [FS_W:0]         rem2_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [LIN_SPAN_W-1:0] lin_span_t;
  typedef logic [LIN_NUM_W-1:0]  lin_num_t;
  typedef logic [LIN_M_W-1:0]    lin_m_t;
  typedef logic [LIN_PROD_W-1:0] lin_prod_t;
  typedef logic [X60_W-1:0]      x60_t;
  typedef logic [MAG_W-1:0]      mag_t;
  typedef logic [M255_W-1:0]     m255_t;
  typedef logic [DIV_PROD_W-1:0] div_prod_t;

  typedef struct packed {
    sample_t shift_sample;
    sample_t brightness_sample;
  } in_item_t;

  typedef struct packed {
    level_t pwm_period;
    level_t pwm_on_time;
  } out_item_t;

  localparam level_t BASE_PERIOD_RST  = 8'd100;
  localparam level_t BASE_PERIOD_HIGH = 8'd195;
  localparam fs_t    FULL_SCALE_RST   = 10'd675;

  localparam sample_t SEG1_IN = 10'd240;
  localparam sample_t SEG2_IN = 10'd523;
  localparam sample_t SEG3_IN = 10'd800;
  localparam sample_t TOP_IN  = 10'd1023;

  localparam level_t SEG1_OUT  = 8'd64;
  localparam level_t SEG2_OUT  = 8'd128;
  localparam level_t SEG3_OUT  = 8'd192;
  localparam level_t TOP_OUT   = 8'd255;
  localparam level_t LEVEL_MIN = 8'd1;
  localparam level_t LEVEL_MAX = 8'hFE;
  localparam level_t ON_MIN    = 8'd5;

  localparam int SHIFT_SPAN = 60;
  localparam int DIV255_D   = 255;

  localparam int LIN_D1 = int'(SEG1_IN);
  localparam int LIN_D2 = int'(SEG2_IN) - int'(SEG1_IN);
  localparam int LIN_D3 = int'(SEG3_IN) - int'(SEG2_IN);
  localparam int LIN_D4 = int'(TOP_IN) - int'(SEG3_IN);

  localparam level_t LIN_S1 = SEG1_OUT;
  localparam level_t LIN_S2 = SEG2_OUT - SEG1_OUT;
  localparam level_t LIN_S3 = SEG3_OUT - SEG2_OUT;
  localparam level_t LIN_S4 = TOP_OUT - SEG3_OUT;

  localparam lin_m_t LIN_M1 = lin_m_t'(((1 << LIN_K) + LIN_D1 - 1) / LIN_D1);
  localparam lin_m_t LIN_M2 = lin_m_t'(((1 << LIN_K) + LIN_D2 - 1) / LIN_D2);
  localparam lin_m_t LIN_M3 = lin_m_t'(((1 << LIN_K) + LIN_D3 - 1) / LIN_D3);
  localparam lin_m_t LIN_M4 = lin_m_t'(((1 << LIN_K) + LIN_D4 - 1) / LIN_D4);

  localparam m255_t DIV255_M = m255_t'(((1 << DIV255_K) + DIV255_D - 1) / DIV255_D);

endpackage

>>> rtl/core/ptlps_lin.sv
module ptlps_lin (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           en,
  input  logic                                           in_valid,
  input  ptlps_pkg::in_item_t                            in_data,
  output logic                                           out_valid,
  output ptlps_pkg::level_t [ptlps_pkg::LANES-1:0]       out_lin
);

  ptlps_pkg::sample_t   samp    [ptlps_pkg::LANES];
  ptlps_pkg::sample_t   x0      [ptlps_pkg::LANES];
  ptlps_pkg::level_t    slope   [ptlps_pkg::LANES];
  ptlps_pkg::lin_span_t offs    [ptlps_pkg::LANES];
  ptlps_pkg::lin_num_t  num_nxt [ptlps_pkg::LANES];
  ptlps_pkg::lin_num_t  num_r   [ptlps_pkg::LANES];
  ptlps_pkg::lin_m_t    m_nxt   [ptlps_pkg::LANES];
  ptlps_pkg::lin_m_t    m_r     [ptlps_pkg::LANES];
  ptlps_pkg::level_t    y0_nxt  [ptlps_pkg::LANES];
  ptlps_pkg::level_t    y0a_r   [ptlps_pkg::LANES];
  ptlps_pkg::level_t    y0b_r   [ptlps_pkg::LANES];
  ptlps_pkg::lin_prod_t prod    [ptlps_pkg::LANES];
  ptlps_pkg::level_t    q_nxt   [ptlps_pkg::LANES];
  ptlps_pkg::level_t    q_r     [ptlps_pkg::LANES];
  ptlps_pkg::level_t    lin_nxt [ptlps_pkg::LANES];
  ptlps_pkg::level_t    lin_r   [ptlps_pkg::LANES];
  logic [ptlps_pkg::LIN_STAGES-1:0] valid_r;

  assign samp[ptlps_pkg::LANE_SHIFT]  = in_data.shift_sample;
  assign samp[ptlps_pkg::LANE_BRIGHT] = in_data.brightness_sample;

  always_comb begin
    for (int i = 0; i < ptlps_pkg::LANES; i++) begin
      if (samp[i] < ptlps_pkg::SEG1_IN) begin
        x0[i]     = '0;
        slope[i]  = ptlps_pkg::LIN_S1;
        m_nxt[i]  = ptlps_pkg::LIN_M1;
        y0_nxt[i] = '0;
      end else if (samp[i] < ptlps_pkg::SEG2_IN) begin
        x0[i]     = ptlps_pkg::SEG1_IN;
        slope[i]  = ptlps_pkg::LIN_S2;
        m_nxt[i]  = ptlps_pkg::LIN_M2;
        y0_nxt[i] = ptlps_pkg::SEG1_OUT;
      end else if (samp[i] < ptlps_pkg::SEG3_IN) begin
        x0[i]     = ptlps_pkg::SEG2_IN;
        slope[i]  = ptlps_pkg::LIN_S3;
        m_nxt[i]  = ptlps_pkg::LIN_M3;
        y0_nxt[i] = ptlps_pkg::SEG2_OUT;
      end else begin
        x0[i]     = ptlps_pkg::SEG3_IN;
        slope[i]  = ptlps_pkg::LIN_S4;
        m_nxt[i]  = ptlps_pkg::LIN_M4;
        y0_nxt[i] = ptlps_pkg::SEG3_OUT;
      end
      offs[i]    = ptlps_pkg::lin_span_t'(samp[i] - x0[i]);
      num_nxt[i] = ptlps_pkg::lin_num_t'(offs[i]) * ptlps_pkg::lin_num_t'(slope[i]);
      prod[i]    = ptlps_pkg::lin_prod_t'(num_r[i]) * ptlps_pkg::lin_prod_t'(m_r[i]);
      q_nxt[i]   = prod[i][ptlps_pkg::LIN_K +: ptlps_pkg::TICK_W];
      lin_nxt[i] = q_r[i] + y0b_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[ptlps_pkg::LIN_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_nxt;
      m_r   <= m_nxt;
      y0a_r <= y0_nxt;
      q_r   <= q_nxt;
      y0b_r <= y0a_r;
      lin_r <= lin_nxt;
    end
  end

  assign out_valid = valid_r[ptlps_pkg::LIN_STAGES-1];

  always_comb begin
    for (int i = 0; i < ptlps_pkg::LANES; i++) begin
      out_lin[i] = lin_r[i];
    end
  end

endmodule

>>> rtl/core/ptlps_lvl.sv
`include "pot_to_led_pwm_setting_defines.svh"

module ptlps_lvl (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     en,
  input  logic                                     in_valid,
  input  ptlps_pkg::level_t [ptlps_pkg::LANES-1:0] in_lin,
  input  ptlps_pkg::fs_t                           full_scale,
  output logic                                     out_valid,
  output ptlps_pkg::level_t [ptlps_pkg::LANES-1:0] out_level
);

  localparam int LAST = ptlps_pkg::DIV_STAGES;

  ptlps_pkg::fs_t    rem_nxt [LAST+1][ptlps_pkg::LANES];
  ptlps_pkg::fs_t    rem_r   [LAST+1][ptlps_pkg::LANES];
  ptlps_pkg::level_t quo_nxt [LAST+1][ptlps_pkg::LANES];
  ptlps_pkg::level_t quo_r   [LAST+1][ptlps_pkg::LANES];
  logic              sat_nxt [LAST+1][ptlps_pkg::LANES];
  logic              sat_r   [LAST+1][ptlps_pkg::LANES];
  logic [LAST:0]     valid_r;

  always_comb begin
    ptlps_pkg::fs_t    r;
    ptlps_pkg::level_t q;
    ptlps_pkg::rem2_t  t;
    for (int i = 0; i < ptlps_pkg::LANES; i++) begin
      sat_nxt[0][i] = ptlps_pkg::fs_t'(in_lin[i]) >= full_scale;
      rem_nxt[0][i] = ptlps_pkg::fs_t'(in_lin[i]);
      quo_nxt[0][i] = '0;
    end
    for (int k = 1; k <= LAST; k++) begin
      for (int i = 0; i < ptlps_pkg::LANES; i++) begin
        r = rem_r[k-1][i];
        q = quo_r[k-1][i];
        for (int b = 0; b < ptlps_pkg::DIV_BITS; b++) begin
          t = {r, 1'b0};
          if (t >= {1'b0, full_scale}) begin
            r = ptlps_pkg::fs_t'(t - {1'b0, full_scale});
            q = {q[ptlps_pkg::TICK_W-2:0], 1'b1};
          end else begin
            r = t[ptlps_pkg::FS_W-1:0];
            q = {q[ptlps_pkg::TICK_W-2:0], 1'b0};
          end
        end
        rem_nxt[k][i] = r;
        quo_nxt[k][i] = q;
        sat_nxt[k][i] = sat_r[k-1][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[LAST-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_valid = valid_r[LAST];

  always_comb begin
    for (int i = 0; i < ptlps_pkg::LANES; i++) begin
      if (sat_r[LAST][i]) begin
        out_level[i] = ptlps_pkg::LEVEL_MAX;
      end else if (quo_r[LAST][i] == '0) begin
        out_level[i] = ptlps_pkg::LEVEL_MIN;
      end else if (quo_r[LAST][i] > ptlps_pkg::LEVEL_MAX) begin
        out_level[i] = ptlps_pkg::LEVEL_MAX;
      end else begin
        out_level[i] = quo_r[LAST][i];
      end
    end
  end

  `PTLPS_ASSERT(a_shift_rem_below_fs, valid_r[LAST] && !sat_r[LAST][ptlps_pkg::LANE_SHIFT] |-> rem_r[LAST][ptlps_pkg::LANE_SHIFT] < full_scale, "shift remainder not below full scale")
  `PTLPS_ASSERT(a_bright_rem_below_fs, valid_r[LAST] && !sat_r[LAST][ptlps_pkg::LANE_BRIGHT] |-> rem_r[LAST][ptlps_pkg::LANE_BRIGHT] < full_scale, "brightness remainder not below full scale")

endmodule

>>> rtl/core/ptlps_pwm.sv
`include "pot_to_led_pwm_setting_defines.svh"

module ptlps_pwm (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     en,
  input  logic                                     in_valid,
  input  ptlps_pkg::level_t [ptlps_pkg::LANES-1:0] in_level,
  input  ptlps_pkg::level_t                        base_period,
  output logic                                     out_valid,
  output ptlps_pkg::out_item_t                     out_data
);

  logic [ptlps_pkg::PWM_STAGES-1:0] valid_r;

  ptlps_pkg::x60_t      x60_nxt, x60_r;
  ptlps_pkg::level_t    lb1_r, lb2_r, lb3_r;
  ptlps_pkg::div_prod_t prod_s, prod_o;
  ptlps_pkg::level_t    sh_nxt, sh_r;
  ptlps_pkg::level_t    period_nxt, period3_r, period4_r, period5_r;
  logic                 neg_nxt, neg3_r, neg4_r, neg5_r;
  ptlps_pkg::level_t    abs_nxt, abs_r;
  ptlps_pkg::mag_t      mag_nxt, mag_r;
  ptlps_pkg::level_t    q_nxt, q_r;
  ptlps_pkg::level_t    on_nxt;
  ptlps_pkg::out_item_t out_nxt, out_r;

  always_comb begin
    x60_nxt    = ptlps_pkg::x60_t'(in_level[ptlps_pkg::LANE_SHIFT]) *
                 ptlps_pkg::x60_t'(ptlps_pkg::SHIFT_SPAN);
    prod_s     = ptlps_pkg::div_prod_t'(x60_r) * ptlps_pkg::div_prod_t'(ptlps_pkg::DIV255_M);
    sh_nxt     = prod_s[ptlps_pkg::DIV255_K +: ptlps_pkg::TICK_W];
    period_nxt = ptlps_pkg::level_t'(base_period + sh_r);
    neg_nxt    = period_nxt < ptlps_pkg::ON_MIN;
    abs_nxt    = neg_nxt ? ptlps_pkg::ON_MIN - period_nxt : period_nxt - ptlps_pkg::ON_MIN;
    mag_nxt    = ptlps_pkg::mag_t'(lb3_r) * ptlps_pkg::mag_t'(abs_r);
    prod_o     = ptlps_pkg::div_prod_t'(mag_r) * ptlps_pkg::div_prod_t'(ptlps_pkg::DIV255_M);
    q_nxt      = prod_o[ptlps_pkg::DIV255_K +: ptlps_pkg::TICK_W];
    on_nxt     = neg5_r ? ptlps_pkg::ON_MIN - q_r : ptlps_pkg::ON_MIN + q_r;
    out_nxt.pwm_period  = period5_r;
    out_nxt.pwm_on_time = on_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[ptlps_pkg::PWM_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x60_r     <= x60_nxt;
      lb1_r     <= in_level[ptlps_pkg::LANE_BRIGHT];
      sh_r      <= sh_nxt;
      lb2_r     <= lb1_r;
      period3_r <= period_nxt;
      neg3_r    <= neg_nxt;
      abs_r     <= abs_nxt;
      lb3_r     <= lb2_r;
      mag_r     <= mag_nxt;
      period4_r <= period3_r;
      neg4_r    <= neg3_r;
      q_r       <= q_nxt;
      period5_r <= period4_r;
      neg5_r    <= neg4_r;
      out_r     <= out_nxt;
    end
  end

  assign out_valid = valid_r[ptlps_pkg::PWM_STAGES-1];
  assign out_data  = out_r;

  `PTLPS_ASSERT(a_on_in_range, out_valid && out_r.pwm_period >= ptlps_pkg::ON_MIN |-> out_r.pwm_on_time >= ptlps_pkg::ON_MIN && out_r.pwm_on_time <= out_r.pwm_period, "on time outside five to period")

endmodule

>>> rtl/core/pot_to_led_pwm_setting.sv
// LED PWM setting from two potentiometer samples.
// Input channel: in_valid / in_stall / in_data carry one pair of 10-bit
// samples (shift, brightness); a transfer happens when in_valid is high and
// in_stall is low. Result channel: out_valid / out_stall / out_data carry
// the 8-bit PWM period and on-time in the same order as the inputs.
// Configuration: cfg_wr_en with cfg_index and cfg_wdata writes base_period
// or adc_full_scale, which is registered; write only while no item is in flight.
// Throughput: one pair per cycle, sustained while out_stall stays low.
// Pipeline: three stages of segment map, one setup stage plus four two-bit
// stages of the level divider, six stages of period and on-time
// arithmetic, between an input transfer and its result on out_valid.
// The whole pipeline advances as one; when a result is held by out_stall,
// every stage holds and in_stall rises in the same cycle.
// Reset (rst_n low, synchronous) clears all stage valid bits and loads
// base_period 100 and adc_full_scale 675.
`include "pot_to_led_pwm_setting_defines.svh"

module pot_to_led_pwm_setting (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ptlps_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ptlps_pkg::out_item_t out_data,
  input  logic                 cfg_wr_en,
  input  ptlps_pkg::cfg_idx_t  cfg_index,
  input  ptlps_pkg::cfg_data_t cfg_wdata
);

  ptlps_pkg::level_t base_period_nxt, base_period_r;
  ptlps_pkg::fs_t    full_scale_nxt, full_scale_r;
  logic              pipe_en;
  logic              lin_valid, lvl_valid;

  ptlps_pkg::level_t [ptlps_pkg::LANES-1:0] lin;
  ptlps_pkg::level_t [ptlps_pkg::LANES-1:0] level;

  always_comb begin
    base_period_nxt = base_period_r;
    full_scale_nxt  = full_scale_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        ptlps_pkg::CFG_BASE_PERIOD: begin
          base_period_nxt = cfg_wdata[ptlps_pkg::TICK_W-1:0];
        end
        ptlps_pkg::CFG_ADC_FULL_SCALE: begin
          full_scale_nxt = cfg_wdata[ptlps_pkg::FS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_period_r <= ptlps_pkg::BASE_PERIOD_RST;
      full_scale_r  <= ptlps_pkg::FULL_SCALE_RST;
    end else begin
      base_period_r <= base_period_nxt;
      full_scale_r  <= full_scale_nxt;
    end
  end

  // hold every stage while the finished result waits
  assign pipe_en  = !out_valid || !out_stall;
  assign in_stall = !pipe_en;

  ptlps_lin u_lin (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (lin_valid),
    .out_lin   (lin)
  );

  ptlps_lvl u_lvl (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (pipe_en),
    .in_valid   (lin_valid),
    .in_lin     (lin),
    .full_scale (full_scale_r),
    .out_valid  (lvl_valid),
    .out_level  (level)
  );

  ptlps_pwm u_pwm (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (pipe_en),
    .in_valid    (lvl_valid),
    .in_level    (level),
    .base_period (base_period_r),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

  `PTLPS_ASSERT_RST(a_reset_empties, !rst_n |=> !out_valid, "result valid right after reset")
  `PTLPS_ASSERT(a_period_no_wrap, out_valid && base_period_r <= ptlps_pkg::BASE_PERIOD_HIGH |-> out_data.pwm_period >= base_period_r, "period below base without overflow")

endmodule

>>> tb/tb_top.sv
module tb_top;
  import ptlps_pkg::*;

  localparam int N_ROWS      = 23;
  localparam int PHASES      = 8;
  localparam int PRESS_PHASE = 3;
  localparam int PHASE_ITEMS = 110;
  localparam int PRESS_ITEMS = 200;
  localparam int HOLD_CYCLES = 64;
  localparam int TAIL_CYCLES = 20;
  localparam int RUN_LIMIT   = 600000;

  typedef struct packed {
    cfg_data_t base;
    fs_t       fs;
    sample_t   shift;
    sample_t   bright;
    logic      typed;
    out_item_t want;
  } probe_row_t;

  localparam probe_row_t PROBE_ROWS [N_ROWS] = '{
    '{10'd100, 10'd675, 10'd0,    10'd0,    1'b1, '{8'd100, 8'd5}},
    '{10'd100, 10'd675, 10'd1023, 10'd1023, 1'b0, '0},
    '{10'd100, 10'd675, 10'd239,  10'd240,  1'b0, '0},
    '{10'd100, 10'd675, 10'd240,  10'd239,  1'b0, '0},
    '{10'd100, 10'd675, 10'd522,  10'd523,  1'b0, '0},
    '{10'd100, 10'd675, 10'd523,  10'd522,  1'b0, '0},
    '{10'd100, 10'd675, 10'd799,  10'd800,  1'b0, '0},
    '{10'd100, 10'd675, 10'd800,  10'd799,  1'b0, '0},
    '{10'd100, 10'd675, 10'd1023, 10'd0,    1'b0, '0},
    '{10'd100, 10'd675, 10'd0,    10'd1023, 1'b0, '0},
    '{10'd100, 10'd675, 10'h2AA,  10'h155,  1'b0, '0},
    '{10'd100, 10'd675, 10'h155,  10'h2AA,  1'b0, '0},
    '{10'd195, 10'd675, 10'd0,    10'd0,    1'b1, '{8'd195, 8'd5}},
    '{10'd195, 10'd675, 10'd1023, 10'd1023, 1'b0, '0},
    '{10'd5,   10'd1,   10'd0,    10'd0,    1'b1, '{8'd5, 8'd5}},
    '{10'd5,   10'd1,   10'd1,    10'd1023, 1'b0, '0},
    '{10'd5,   10'd1,   10'd1023, 10'd1023, 1'b0, '0},
    '{10'd0,   10'd675, 10'd0,    10'd0,    1'b1, '{8'd0, 8'd5}},
    '{10'd0,   10'd675, 10'd1023, 10'd0,    1'b0, '0},
    '{10'd0,   10'd0,   10'd0,    10'd1023, 1'b0, '0},
    '{10'd255, 10'd0,   10'd1023, 10'd1023, 1'b0, '0},
    '{10'h3FF, 10'd675, 10'd0,    10'd0,    1'b1, '{8'd255, 8'd5}},
    '{10'd200, 10'd0,   10'd0,    10'd1023, 1'b0, '0}
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_wr_en = 1'b0;
  cfg_idx_t  cfg_index = CFG_BASE_PERIOD;
  cfg_data_t cfg_wdata = '0;

  logic      row_typed = 1'b0;
  out_item_t row_want  = '0;
  logic      quiet     = 1'b0;
  logic      hold_req  = 1'b0;
  bit        hold_served;
  bit        stall_now;
  int        stall_left;

  level_t    base_shadow       = 8'd100;
  fs_t       full_scale_shadow = 10'd675;
  out_item_t pwm_pending [$];
  int        mismatch_count;

  pot_to_led_pwm_setting u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned ramp(input int unsigned x, input int unsigned x0,
                                       input int unsigned x1, input int unsigned y0,
                                       input int unsigned y1);
    return (x - x0) * (y1 - y0) / (x1 - x0) + y0;
  endfunction

  function automatic int unsigned sample_to_level(input sample_t s, input fs_t fs);
    int unsigned x;
    int unsigned lin;
    int unsigned fsu;
    int unsigned lvl;
    x   = 32'(s);
    fsu = 32'(fs);
    if (x < 240)
      lin = ramp(x, 0, 240, 0, 64);
    else if (x < 523)
      lin = ramp(x, 240, 523, 64, 128);
    else if (x < 800)
      lin = ramp(x, 523, 800, 128, 192);
    else
      lin = ramp(x, 800, 1023, 192, 255);
    if (lin >= fsu)
      lvl = 255;
    else
      lvl = ((lin << 8) / fsu) & 32'hFF;
    if (lvl == 0)
      lvl = 1;
    else if (lvl > 254)
      lvl = 254;
    return lvl;
  endfunction

  function automatic out_item_t predict_pwm(input in_item_t it);
    int unsigned shift_lvl;
    int unsigned bright_lvl;
    int unsigned period;
    int          span;
    int          on_ticks;
    out_item_t   res;
    shift_lvl  = sample_to_level(it.shift_sample, full_scale_shadow);
    bright_lvl = sample_to_level(it.brightness_sample, full_scale_shadow);
    period     = (int'(base_shadow) + shift_lvl * 60 / 255) & 32'hFF;
    span       = int'(period) - 5;
    on_ticks   = (int'(bright_lvl) * span) / 255 + 5;
    res.pwm_period  = period[7:0];
    res.pwm_on_time = on_ticks[7:0];
    return res;
  endfunction

  function automatic sample_t pick_sample();
    int v;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 0;
          1: v = 240;
          2: v = 523;
          3: v = 800;
          default: v = 1023;
        endcase
        v = v + int'($urandom_range(0, 4)) - 2;
        if (v < 0)
          v = 0;
        if (v > 1023)
          v = 1023;
      end
      1: v = $urandom_range(0, 31);
      2: v = $urandom_range(992, 1023);
      default: v = $urandom_range(0, 1023);
    endcase
    return sample_t'(v);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch @%0t: %s", $time, what);
  endtask

  always @(posedge clk) begin : pwm_check
    out_item_t want;
    if (!rst_n) begin
      base_shadow       = 8'd100;
      full_scale_shadow = 10'd675;
    end else begin
      if (in_valid && !in_stall)
        pwm_pending.push_back(row_typed ? row_want : predict_pwm(in_data));
      if (cfg_wr_en) begin
        if (cfg_index == CFG_BASE_PERIOD)
          base_shadow = cfg_wdata[7:0];
        else if (cfg_index == CFG_ADC_FULL_SCALE)
          full_scale_shadow = cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        if (pwm_pending.size() == 0) begin
          report_mismatch("result transfer with nothing pending");
        end else begin
          want = pwm_pending.pop_front();
          if (out_data.pwm_period !== want.pwm_period)
            report_mismatch($sformatf("pwm_period got %0d want %0d",
                                      out_data.pwm_period, want.pwm_period));
          if (out_data.pwm_on_time !== want.pwm_on_time)
            report_mismatch($sformatf("pwm_on_time got %0d want %0d",
                                      out_data.pwm_on_time, want.pwm_on_time));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left == 0) begin
        if (hold_req && !hold_served) begin
          stall_now   = 1'b1;
          stall_left  = HOLD_CYCLES;
          hold_served = 1'b1;
        end else if (quiet) begin
          stall_now  = 1'b0;
          stall_left = 1;
        end else if ($urandom_range(0, 2) == 0) begin
          stall_now  = 1'b1;
          stall_left = $urandom_range(1, 16);
        end else begin
          stall_now  = 1'b0;
          stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 80)
                                                   : $urandom_range(1, 16);
        end
      end
      out_stall <= stall_now;
      stall_left--;
    end
  end

  task automatic send_pair(input in_item_t it, input bit allow_gap);
    if (allow_gap && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pwm_pending.size() != 0);
  endtask

  task automatic load_settings(input cfg_data_t base, input fs_t fs);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_BASE_PERIOD;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= CFG_ADC_FULL_SCALE;
    cfg_wdata <= fs;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    cfg_data_t cur_base;
    fs_t       cur_fs;
    cfg_data_t base;
    fs_t       fs;
    in_item_t  it;
    int        n;
    cur_base = 10'd100;
    cur_fs   = 10'd675;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (PROBE_ROWS[i]) begin
      if (PROBE_ROWS[i].base != cur_base || PROBE_ROWS[i].fs != cur_fs) begin
        wait_drained();
        cur_base = PROBE_ROWS[i].base;
        cur_fs   = PROBE_ROWS[i].fs;
        load_settings(cur_base, cur_fs);
      end
      row_typed <= PROBE_ROWS[i].typed;
      row_want  <= PROBE_ROWS[i].want;
      it.shift_sample      = PROBE_ROWS[i].shift;
      it.brightness_sample = PROBE_ROWS[i].bright;
      send_pair(it, 1'b1);
    end
    row_typed <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin base = 10'd100; fs = 10'd675; end
        1: begin base = 10'd5;   fs = 10'd1;    end
        2: begin base = 10'd195; fs = 10'd1023; end
        3: begin
          base = cfg_data_t'($urandom_range(5, 195));
          fs   = fs_t'($urandom_range(1, 1023));
        end
        4: begin base = 10'd0;   fs = 10'd0;    end
        5: begin
          base = 10'h3FF;
          fs   = fs_t'($urandom_range(0, 1023));
        end
        6: begin
          base = cfg_data_t'($urandom_range(0, 1023));
          fs   = fs_t'($urandom_range(0, 1023));
        end
        default: begin
          base = cfg_data_t'($urandom_range(5, 195));
          fs   = fs_t'($urandom_range(200, 1023));
        end
      endcase
      if (p == PRESS_PHASE)
        hold_req <= 1'b1;
      if (p == PHASES - 1)
        quiet <= 1'b1;
      load_settings(base, fs);
      n = (p == PRESS_PHASE) ? PRESS_ITEMS : PHASE_ITEMS;
      repeat (n) begin
        it.shift_sample      = pick_sample();
        it.brightness_sample = pick_sample();
        send_pair(it, p != PRESS_PHASE);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ptlps_pkg.sv
rtl/core/ptlps_lin.sv
rtl/core/ptlps_lvl.sv
rtl/core/ptlps_pwm.sv
rtl/core/pot_to_led_pwm_setting.sv
tb/tb_top.sv
